// ===== hdl/shlcg_pkg.sv =====
// shared constants and arithmetic helpers for the shuffled lehmer generator
package shlcg_pkg;

  localparam int VALUE_W = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = VALUE_W + MULT_W;

  localparam int DEPTH_DEFAULT = 32;
  localparam int WARM_EXTRA = 8;

  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SAMPLE_MAX = 31'd2147483389;
  localparam logic [VALUE_W-1:0] SEED_RESET = 31'd1;

  // reduce a product of a value and the multiplier modulo 2^31-1
  function automatic logic [VALUE_W-1:0] lcg_fold(input logic [PROD_W-1:0] prod);
    logic [VALUE_W:0] sum;
    sum = {1'b0, prod[VALUE_W-1:0]} + {{(VALUE_W + 1 - MULT_W){1'b0}}, prod[PROD_W-1:VALUE_W]};
    if (sum >= {1'b0, LCG_MOD}) begin
      sum = sum - {1'b0, LCG_MOD};
    end
    return sum[VALUE_W-1:0];
  endfunction

  // zero and the modulus itself both load as one
  function automatic logic [VALUE_W-1:0] seed_fix(input logic [VALUE_W-1:0] seed);
    logic [VALUE_W-1:0] x;
    x = seed;
    if (x == '0 || x == LCG_MOD) begin
      x = 31'd1;
    end
    return x;
  endfunction

  // clamp a drawn entry to the largest sample
  function automatic logic [VALUE_W-1:0] sample_clamp(input logic [VALUE_W-1:0] v);
    return (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
  endfunction

endpackage

// ===== hdl/shlcg_table_ram.sv =====
// shuffle table memory, one write port and one registered read port
module shlcg_table_ram
  import shlcg_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VALUE_W-1:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VALUE_W-1:0]       rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/shlcg_lcg_step.sv =====
// lehmer step: registered product, then fold modulo 2^31-1
module shlcg_lcg_step
  import shlcg_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [VALUE_W-1:0] x,
  output logic [VALUE_W-1:0] y
);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(x) * PROD_W'(LCG_MULT);
    end
  end

  assign y = lcg_fold(prod);

endmodule

// ===== hdl/shlcg_slot_calc.sv =====
// table index from the held value: reciprocal estimate, then one correction
module shlcg_slot_calc
  import shlcg_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic [VALUE_W-1:0]       value,
  input  logic [VALUE_W-1:0]       held,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int IW = $clog2(DEPTH);
  localparam int EW = $clog2(DEPTH + 1);
  localparam int SCALE_SH = 40;
  localparam longint SLOT_DIV_L = 1 + (longint'(LCG_MOD) - 1) / DEPTH;
  localparam longint RECIP_L = (longint'(1) <<< SCALE_SH) / SLOT_DIV_L;
  localparam int RW = $clog2(RECIP_L + 1);
  localparam int PW = VALUE_W + RW;
  localparam int TW = VALUE_W + EW + 1;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [TW-1:0] SLOT_DIV = TW'(SLOT_DIV_L);
  localparam logic [EW:0] SLOT_LAST = (EW + 1)'(DEPTH - 1);

  logic [EW-1:0] est;
  logic [PW-1:0] prod;
  logic [TW-1:0] thresh;
  logic [EW:0]   fixed;

  assign prod = PW'(value) * PW'(RECIP);

  // estimate is the true quotient or one below it
  always_ff @(posedge clk) begin
    if (load) begin
      est <= EW'(prod >> SCALE_SH);
    end
  end

  always_comb begin
    thresh = (TW'(est) + TW'(1)) * SLOT_DIV;
    fixed = {1'b0, est};
    if (TW'(held) >= thresh) begin
      fixed = fixed + (EW + 1)'(1);
    end
    if (fixed > SLOT_LAST) begin
      fixed = SLOT_LAST;
    end
    slot = fixed[IW-1:0];
  end

endmodule

// ===== hdl/shuffled_lehmer_random_generator.sv =====
// top level: lehmer generator behind a bays-durham shuffle table in memory
// a plain draw runs from input transfer to result as a memory read of the
// chosen entry, then write-back of the new generator value in its place
// write-back waits on an untaken result; a new request is taken only after it
// a warm-up (reseed, or first request after reset) runs first and refills the table
// rst is synchronous: seed returns to 1, the held value clears so the next
// request warms up; the table is not cleared and needs no clearing pass
module shuffled_lehmer_random_generator
  import shlcg_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [VALUE_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               reseed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] sample
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + WARM_EXTRA);
  localparam logic [CW-1:0] WARM_FIRST = CW'(TABLE_DEPTH + WARM_EXTRA - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_WRITE     = 3'd1;
  localparam logic [2:0] ST_WARM_MUL  = 3'd2;
  localparam logic [2:0] ST_WARM_FOLD = 3'd3;
  localparam logic [2:0] ST_WARM_SLOT = 3'd4;
  localparam logic [2:0] ST_DRAW_RD   = 3'd5;

  logic [2:0]         state;
  logic [CW-1:0]      cnt;
  logic [VALUE_W-1:0] seed;
  logic [VALUE_W-1:0] gen;
  logic [VALUE_W-1:0] held;
  logic [IW-1:0]      rd_slot;

  logic               in_xfer;
  logic               need_warm;
  logic               issue_read;
  logic               advance;
  logic               warm_write;
  logic               lcg_load;
  logic [VALUE_W-1:0] lcg_y;
  logic [IW-1:0]      slot;
  logic               slot_load;
  logic [VALUE_W-1:0] slot_value;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] rdata;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer = in_valid && in_ready;
  // a held value of zero only exists after reset, before the next warm-up
  assign need_warm = reseed || (held == '0);

  // table read of the entry picked by the held value
  assign issue_read = (in_xfer && !need_warm) || (state == ST_DRAW_RD);
  // write-back waits while the output register still holds an untaken result
  assign advance = (state == ST_WRITE) && (!out_valid || out_ready);
  assign warm_write = (state == ST_WARM_FOLD) && (cnt < DEPTH_CNT);

  assign lcg_load = issue_read || (state == ST_WARM_MUL);

  // index estimate comes from the read data on a draw, from held after warm-up
  assign slot_load = advance || (state == ST_WARM_SLOT);
  assign slot_value = (state == ST_WRITE) ? rdata : held;

  assign ram_we = warm_write || advance;
  assign ram_waddr = (state == ST_WARM_FOLD) ? cnt[IW-1:0] : rd_slot;

  shlcg_lcg_step u_lcg (
    .clk  (clk),
    .load (lcg_load),
    .x    (gen),
    .y    (lcg_y)
  );

  shlcg_slot_calc #(
    .DEPTH (TABLE_DEPTH)
  ) u_slot (
    .clk   (clk),
    .load  (slot_load),
    .value (slot_value),
    .held  (held),
    .slot  (slot)
  );

  shlcg_table_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (lcg_y),
    .re    (issue_read),
    .raddr (slot),
    .rdata (rdata)
  );

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_write) begin
      seed <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held <= '0;
      gen <= '0;
      out_valid <= 1'b0;
    end else begin
      // a taken result clears unless a new one lands in the same cycle
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (need_warm) begin
              gen <= seed_fix(seed);
              cnt <= WARM_FIRST;
              state <= ST_WARM_MUL;
            end else begin
              rd_slot <= slot;
              state <= ST_WRITE;
            end
          end
        end
        ST_DRAW_RD: begin
          rd_slot <= slot;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (advance) begin
            // the entry read becomes the result and the new held value
            held <= rdata;
            gen <= lcg_y;
            sample <= sample_clamp(rdata);
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_WARM_MUL: begin
          state <= ST_WARM_FOLD;
        end
        ST_WARM_FOLD: begin
          // table fills from the top entry down, entry 0 last
          gen <= lcg_y;
          if (cnt == '0) begin
            held <= lcg_y;
            state <= ST_WARM_SLOT;
          end else begin
            cnt <= cnt - CW'(1);
            state <= ST_WARM_MUL;
          end
        end
        ST_WARM_SLOT: begin
          state <= ST_DRAW_RD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/shlcg_checker.sv =====
// port-level checks on the shuffled lehmer generator, bound to the top level
module shlcg_checker
  import shlcg_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] sample
);

  // a waiting result holds its value until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("result changed while waiting");

  // every result is a nonzero clamped fraction
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample != '0) && (sample <= SAMPLE_MAX))
    else $error("sample out of range");

  // one item at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

  // reset leaves no result pending
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind shuffled_lehmer_random_generator shlcg_checker u_shlcg_checker (.*);
